// ===== hdl/lmps_pkg.sv =====
package lmps_pkg;

    localparam int SLOT_TICKS = 624;
    localparam int LED_COUNT  = 64;
    localparam int ROW_COUNT  = LED_COUNT / 2;
    localparam int ROW_AW     = $clog2(ROW_COUNT);
    localparam int LEVEL_W    = 4;
    localparam int TICK_W     = 10;
    localparam int COL_COUNT  = 8;
    localparam int COL_W      = 3;
    localparam int PAIR_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int DATA_W     = 8;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [5:0]          led_index;
        logic [LEVEL_W-1:0]  level;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] row_drive;
        logic [DATA_W-1:0] column_drive;
        logic              frame_start;
    } result_t;

    // scan position handed from the counters to the drive stage
    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [PAIR_W-1:0] pair;
        logic [DATA_W-1:0] pattern;
        logic              frame;
    } pos_t;

    function automatic logic [TICK_W-1:0] on_time(input logic [LEVEL_W-1:0] lv);
        logic [TICK_W-1:0] t;
        case (lv)
            4'd0:    t = 10'd1;
            4'd1:    t = 10'd1;
            4'd2:    t = 10'd2;
            4'd3:    t = 10'd3;
            4'd4:    t = 10'd4;
            4'd5:    t = 10'd8;
            4'd6:    t = 10'd16;
            4'd7:    t = 10'd28;
            4'd8:    t = 10'd52;
            4'd9:    t = 10'd100;
            4'd10:   t = 10'd160;
            4'd11:   t = 10'd220;
            4'd12:   t = 10'd320;
            4'd13:   t = 10'd400;
            4'd14:   t = 10'd500;
            4'd15:   t = 10'd623;
            default: t = 10'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== hdl/led_matrix_pwm_scanner_core.sv =====
// a result follows its item transfer through the store read, then the drive register
// throughput: one item per cycle unless stalled; each tick or level write gives exactly one result
// the level store is two 32x4 rams read at the scanned row, write-through forwarded
// reset clears counters, column patterns and the per-led valid bits, so every level reads
// as zero until written; no clearing pass, items are taken right after reset
module led_matrix_pwm_scanner_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  lmps_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output lmps_pkg::result_t               result,
    input  logic                            cfg_write,
    input  logic [lmps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmps_pkg::DATA_W-1:0]     cfg_data
);

    logic                          accept;
    logic                          wr_en;
    lmps_pkg::pos_t                pos;
    logic [lmps_pkg::ROW_AW-1:0]   rd_addr;
    logic [lmps_pkg::LEVEL_W-1:0]  lo_level, hi_level;

    assign accept = item_valid & ~item_stall;
    assign wr_en  = accept & (item.opcode == lmps_pkg::OP_WRITE);

    lmps_scan_ctrl u_scan_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (item.opcode),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos       (pos),
        .rd_addr   (rd_addr)
    );

    lmps_level_store u_level_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (item.led_index[lmps_pkg::ROW_AW-1:0]),
        .wr_half  (item.led_index[lmps_pkg::ROW_AW]),
        .wr_level (item.level),
        .lo_level (lo_level),
        .hi_level (hi_level)
    );

    lmps_pwm_out u_pwm_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .pos          (pos),
        .lo_level     (lo_level),
        .hi_level     (hi_level),
        .result_stall (result_stall),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== hdl/lmps_level_ram.sv =====
module lmps_level_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lmps_level_store.sv =====
module lmps_level_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [lmps_pkg::ROW_AW-1:0]   rd_addr,
    input  logic                          wr_en,
    input  logic [lmps_pkg::ROW_AW-1:0]   wr_addr,
    input  logic                          wr_half,
    input  logic [lmps_pkg::LEVEL_W-1:0]  wr_level,
    output logic [lmps_pkg::LEVEL_W-1:0]  lo_level,
    output logic [lmps_pkg::LEVEL_W-1:0]  hi_level
);

    logic [lmps_pkg::ROW_COUNT-1:0] valid_lo_reg, valid_lo_next;
    logic [lmps_pkg::ROW_COUNT-1:0] valid_hi_reg, valid_hi_next;
    logic                           vld_lo_reg, vld_hi_reg;
    logic                           fwd_lo_reg, fwd_hi_reg;
    logic [lmps_pkg::LEVEL_W-1:0]   fwd_level_reg;
    logic [lmps_pkg::LEVEL_W-1:0]   ram_lo_q, ram_hi_q;
    logic                           wr_lo, wr_hi, hit_lo, hit_hi;

    assign wr_lo  = wr_en & ~wr_half;
    assign wr_hi  = wr_en & wr_half;
    assign hit_lo = wr_lo & (wr_addr == rd_addr);
    assign hit_hi = wr_hi & (wr_addr == rd_addr);

    lmps_level_ram #(
        .DEPTH (lmps_pkg::ROW_COUNT),
        .WIDTH (lmps_pkg::LEVEL_W)
    ) u_ram_lo (
        .clk     (clk),
        .wr_en   (wr_lo),
        .wr_addr (wr_addr),
        .wr_data (wr_level),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_lo_q)
    );

    lmps_level_ram #(
        .DEPTH (lmps_pkg::ROW_COUNT),
        .WIDTH (lmps_pkg::LEVEL_W)
    ) u_ram_hi (
        .clk     (clk),
        .wr_en   (wr_hi),
        .wr_addr (wr_addr),
        .wr_data (wr_level),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_hi_q)
    );

    always_comb
    begin
        valid_lo_next = valid_lo_reg;
        valid_hi_next = valid_hi_reg;
        if (wr_lo)
        begin
            valid_lo_next[wr_addr] = 1'b1;
        end
        if (wr_hi)
        begin
            valid_hi_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_lo_reg <= '0;
            valid_hi_reg <= '0;
        end
        else
        begin
            valid_lo_reg <= valid_lo_next;
            valid_hi_reg <= valid_hi_next;
        end
    end

    // same-cycle write to the row being read is forwarded past the ram
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            vld_lo_reg    <= valid_lo_reg[rd_addr] | hit_lo;
            vld_hi_reg    <= valid_hi_reg[rd_addr] | hit_hi;
            fwd_lo_reg    <= hit_lo;
            fwd_hi_reg    <= hit_hi;
            fwd_level_reg <= wr_level;
        end
    end

    assign lo_level = !vld_lo_reg ? '0 : (fwd_lo_reg ? fwd_level_reg : ram_lo_q);
    assign hi_level = !vld_hi_reg ? '0 : (fwd_hi_reg ? fwd_level_reg : ram_hi_q);

endmodule

// ===== hdl/lmps_scan_ctrl.sv =====
module lmps_scan_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            opcode,
    input  logic                            cfg_write,
    input  logic [lmps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmps_pkg::DATA_W-1:0]     cfg_data,
    output lmps_pkg::pos_t                  pos,
    output logic [lmps_pkg::ROW_AW-1:0]     rd_addr
);

    logic [lmps_pkg::DATA_W-1:0] pattern_reg [lmps_pkg::COL_COUNT];
    logic [lmps_pkg::COL_W-1:0]  column_reg, column_next;
    logic [lmps_pkg::PAIR_W-1:0] pair_reg, pair_next;
    logic [lmps_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [lmps_pkg::TICK_W:0]   tick_inc;

    assign tick_inc = {1'b0, tick_reg} + 1'b1;

    always_comb
    begin
        column_next = column_reg;
        pair_next   = pair_reg;
        tick_next   = tick_reg;
        if (accept && opcode == lmps_pkg::OP_TICK)
        begin
            if (tick_inc >= (lmps_pkg::TICK_W+1)'(lmps_pkg::SLOT_TICKS))
            begin
                tick_next   = '0;
                pair_next   = pair_reg + 1'b1;
                if (pair_reg == '1)
                begin
                    column_next = column_reg + 1'b1;
                end
            end
            else
            begin
                tick_next = tick_inc[lmps_pkg::TICK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            pair_reg   <= '0;
            tick_reg   <= '0;
            for (int i = 0; i < lmps_pkg::COL_COUNT; i++)
            begin
                pattern_reg[i] <= '0;
            end
        end
        else
        begin
            column_reg <= column_next;
            pair_reg   <= pair_next;
            tick_reg   <= tick_next;
            if (cfg_write && cfg_index < lmps_pkg::CFG_IDX_W'(lmps_pkg::COL_COUNT))
            begin
                pattern_reg[cfg_index[lmps_pkg::COL_W-1:0]] <= cfg_data;
            end
        end
    end

    // row of the store holding LED c+8p (low) and c+32+8p (high)
    assign rd_addr = {pair_reg, column_reg};

    always_comb
    begin
        pos.tick    = tick_reg;
        pos.pair    = pair_reg;
        pos.pattern = pattern_reg[column_reg];
        pos.frame   = (opcode == lmps_pkg::OP_TICK) && column_reg == '0
                      && pair_reg == '0 && tick_reg == '0;
    end

endmodule

// ===== hdl/lmps_pwm_out.sv =====
module lmps_pwm_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  lmps_pkg::pos_t                pos,
    input  logic [lmps_pkg::LEVEL_W-1:0]  lo_level,
    input  logic [lmps_pkg::LEVEL_W-1:0]  hi_level,
    input  logic                          result_stall,
    output logic                          item_stall,
    output logic                          result_valid,
    output lmps_pkg::result_t             result
);

    lmps_pkg::pos_t    pos_reg;
    lmps_pkg::result_t out_reg, out_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              advance, lit_lo, lit_hi;

    assign advance = s1_valid_reg & (~out_valid_reg | ~result_stall);

    assign lit_lo = (lo_level != '0) && (pos_reg.tick < lmps_pkg::on_time(lo_level));
    assign lit_hi = (hi_level != '0) && (pos_reg.tick < lmps_pkg::on_time(hi_level));

    always_comb
    begin
        out_next              = '0;
        out_next.row_drive[{1'b0, pos_reg.pair}] = lit_lo;
        out_next.row_drive[{1'b1, pos_reg.pair}] = lit_hi;
        out_next.column_drive = pos_reg.pattern;
        out_next.frame_start  = pos_reg.frame;
    end

    assign s1_valid_next  = load | (s1_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg <= pos;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign item_stall   = s1_valid_reg & out_valid_reg & result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== verif/led_matrix_pwm_scanner_core_tb.sv =====
`timescale 1ns / 1ps

module led_matrix_pwm_scanner_core_tb;

    // pwm on-time per level, level 0 in the lowest slice
    localparam logic [16*lmps_pkg::TICK_W-1:0] PWM_ON = {
        10'd623, 10'd500, 10'd400, 10'd320, 10'd220, 10'd160, 10'd100, 10'd52,
        10'd28, 10'd16, 10'd8, 10'd4, 10'd3, 10'd2, 10'd1, 10'd1
    };

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           item_valid   = 1'b0;
    logic                           item_stall;
    lmps_pkg::item_t                item         = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    lmps_pkg::result_t              result;
    logic                           cfg_write    = 1'b0;
    logic [lmps_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [lmps_pkg::DATA_W-1:0]    cfg_data     = '0;

    // scanner state as the testbench sees it
    logic [lmps_pkg::LEVEL_W-1:0] led_level [lmps_pkg::LED_COUNT];
    logic [lmps_pkg::DATA_W-1:0]  col_pattern [lmps_pkg::COL_COUNT];
    logic [lmps_pkg::COL_W-1:0]   scan_col;
    logic [lmps_pkg::PAIR_W-1:0]  scan_pair;
    logic [lmps_pkg::TICK_W-1:0]  slot_tick;

    lmps_pkg::item_t   pending_items [$];
    lmps_pkg::result_t expected_drive [$];
    int      planned_ticks = 0;
    int      errors = 0;
    int      send_wait = 0;
    int      send_burst = 0;
    int      recv_wait = 0;
    int      recv_burst = 0;
    bit      want_long_hold = 1'b0;
    bit      long_hold_taken = 1'b0;

    led_matrix_pwm_scanner_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic led_lit(input logic [lmps_pkg::LEVEL_W-1:0] lv);
        return (lv != '0)
               && (slot_tick < PWM_ON[lv*lmps_pkg::TICK_W +: lmps_pkg::TICK_W]);
    endfunction

    // drive for one item at the current scan position, then move the counters
    function automatic lmps_pkg::result_t scan_step(input lmps_pkg::item_t it);
        lmps_pkg::result_t r;
        if (it.opcode == lmps_pkg::OP_WRITE)
            led_level[it.led_index] = it.level;
        r.row_drive = '0;
        if (led_lit(led_level[{1'b0, scan_pair, scan_col}]))
            r.row_drive[{1'b0, scan_pair}] = 1'b1;
        if (led_lit(led_level[{1'b1, scan_pair, scan_col}]))
            r.row_drive[{1'b1, scan_pair}] = 1'b1;
        r.column_drive = col_pattern[scan_col];
        r.frame_start = (it.opcode == lmps_pkg::OP_TICK) && scan_col == '0
                        && scan_pair == '0 && slot_tick == '0;
        if (it.opcode == lmps_pkg::OP_TICK)
        begin
            if (int'(slot_tick) + 1 >= lmps_pkg::SLOT_TICKS)
            begin
                slot_tick = '0;
                if (&scan_pair)
                    scan_col = scan_col + 1'b1;
                scan_pair = scan_pair + 1'b1;
            end
            else
            begin
                slot_tick = slot_tick + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : item_driver
        int gap;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            send_wait = 0;
        end
        else
        begin
            gap = send_wait;
            if (item_valid && !item_stall)
            begin
                expected_drive.push_back(scan_step(item));
                if (send_burst > 0)
                    send_burst--;
                else if ($urandom_range(0, 40) == 0)
                    send_burst = $urandom_range(20, 80);
                gap = (send_burst > 0) ? 0 : $urandom_range(0, 4);
            end
            // a stalled transfer keeps valid and payload as they are
            if (!(item_valid && item_stall))
            begin
                if (gap > 0)
                begin
                    item_valid <= 1'b0;
                    send_wait = gap - 1;
                end
                else if (pending_items.size() > 0)
                begin
                    item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    send_wait = 0;
                end
                else
                begin
                    item_valid <= 1'b0;
                    send_wait = 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        lmps_pkg::result_t want;
        int hold;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            hold = recv_wait;
            if (result_valid && !result_stall)
            begin
                if (expected_drive.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no result, actual %h", $time, result);
                end
                else
                begin
                    want = expected_drive.pop_front();
                    check_field("row_drive", want.row_drive, result.row_drive);
                    check_field("column_drive", want.column_drive, result.column_drive);
                    check_field("frame_start", {7'b0, want.frame_start},
                                {7'b0, result.frame_start});
                end
                if (recv_burst > 0)
                    recv_burst--;
                else if ($urandom_range(0, 40) == 0)
                    recv_burst = $urandom_range(20, 80);
                hold = (recv_burst > 0) ? 0 : $urandom_range(0, 4);
            end
            // one long hold so the block backs up into its input
            if (want_long_hold && !long_hold_taken)
            begin
                hold = 400;
                long_hold_taken = 1'b1;
            end
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                recv_wait = hold - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                recv_wait = 0;
            end
        end
    end

    task automatic queue_tick();
        lmps_pkg::item_t t;
        t.opcode = lmps_pkg::OP_TICK;
        t.led_index = 6'($urandom);
        t.level = (lmps_pkg::LEVEL_W)'($urandom);
        pending_items.push_back(t);
        planned_ticks++;
    endtask

    task automatic queue_write(input logic [5:0] idx,
                               input logic [lmps_pkg::LEVEL_W-1:0] lv);
        lmps_pkg::item_t t;
        t.opcode = lmps_pkg::OP_WRITE;
        t.led_index = idx;
        t.level = lv;
        pending_items.push_back(t);
    endtask

    // mostly one of the two leds on screen at the planned position
    function automatic logic [5:0] aim_led();
        logic [5:0] v;
        int slot;
        slot = planned_ticks / lmps_pkg::SLOT_TICKS;
        if ($urandom_range(0, 9) < 6)
        begin
            v[5] = 1'($urandom_range(0, 1));
            v[4:3] = 2'(slot % 4);
            v[2:0] = 3'((slot / 4) % lmps_pkg::COL_COUNT);
        end
        else
        begin
            v = 6'($urandom_range(0, lmps_pkg::LED_COUNT - 1));
        end
        return v;
    endfunction

    task automatic queue_random(input int n, input int tick_pct);
        int k;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                queue_tick();
            else
                queue_write(aim_led(), (lmps_pkg::LEVEL_W)'($urandom_range(0, 15)));
        end
    endtask

    task automatic queue_scan(input int target);
        while (planned_ticks < target)
        begin
            if ($urandom_range(0, 99) < 95)
                queue_tick();
            else
                queue_write(aim_led(), (lmps_pkg::LEVEL_W)'($urandom_range(0, 15)));
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || item_valid || expected_drive.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // column 0 in the low byte; an out-of-range index is written last
    task automatic set_patterns(input logic [63:0] pats);
        int i;
        for (i = 0; i < lmps_pkg::COL_COUNT + 1; i++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            if (i < lmps_pkg::COL_COUNT)
            begin
                cfg_index <= (lmps_pkg::CFG_IDX_W)'(i);
                cfg_data <= pats[8*i +: 8];
                col_pattern[i] = pats[8*i +: 8];
            end
            else
            begin
                cfg_index <= (lmps_pkg::CFG_IDX_W)'($urandom_range(lmps_pkg::COL_COUNT,
                                                   2**lmps_pkg::CFG_IDX_W - 1));
                cfg_data <= (lmps_pkg::DATA_W)'($urandom);
            end
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        int i;
        for (i = 0; i < lmps_pkg::LED_COUNT; i++)
            led_level[i] = '0;
        for (i = 0; i < lmps_pkg::COL_COUNT; i++)
            col_pattern[i] = '0;
        scan_col = '0;
        scan_pair = '0;
        slot_tick = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: frame start, dark leds, zero column pattern
        queue_tick();
        queue_write(6'd0, 4'd15);
        queue_tick();
        wait_idle();
        set_patterns(64'h8040_2010_0804_00FF);

        // both leds of the first pair, dark level, shortest and longest on-times
        queue_write(6'd32, 4'd15);
        queue_write(6'd0, 4'd0);
        queue_write(6'd0, 4'd1);
        queue_write(6'd63, 4'd15);
        queue_write(6'd8, 4'd8);
        queue_write(6'd40, 4'd14);
        queue_write(6'd32, 4'd1);
        queue_tick();
        queue_write(6'd0, 4'd7);
        queue_write(6'd32, 4'd6);
        queue_tick();
        queue_write(6'd31, 4'd9);
        queue_write(6'd0, 4'd15);
        queue_write(6'd32, 4'd0);
        queue_tick();
        queue_tick();

        queue_random(650, 65);
        wait_idle();
        set_patterns(64'h55AA_55AA_55AA_55AA);

        // receiver holds off while the sender keeps offering
        want_long_hold = 1'b1;
        queue_random(150, 60);
        wait_idle();

        // run past the end of the first slot into the next pair
        queue_scan(lmps_pkg::SLOT_TICKS + 120);
        wait_idle();
        set_patterns({$urandom, $urandom});

        queue_random(600, 50);
        wait_idle();
        repeat (10) @(negedge clk);

        if (errors == 0)
            $display("led_matrix_pwm_scanner_core_tb passed");
        else
            $display("led_matrix_pwm_scanner_core_tb failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("led_matrix_pwm_scanner_core_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lmps_pkg.sv
hdl/lmps_level_ram.sv
hdl/lmps_level_store.sv
hdl/lmps_scan_ctrl.sv
hdl/lmps_pwm_out.sv
hdl/led_matrix_pwm_scanner_core.sv
verif/led_matrix_pwm_scanner_core_tb.sv
